>>> design/ptd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg: shared constants and types for the point-triangle distance block
// Widths of the exact intermediate values, weight format and region codes.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Coordinate and exact intermediate widths
  localparam int unsigned CRD_W   = 32;            // Q16.16 coordinate
  localparam int unsigned DIF_W   = CRD_W + 1;     // coordinate difference
  localparam int unsigned PRD_W   = 2 * DIF_W;     // one term of a dot product
  localparam int unsigned DOT_W   = PRD_W + 2;     // dot product of 3 terms
  localparam int unsigned HALF_W  = DOT_W / 2;     // split of a dot product
  localparam int unsigned PP_W    = 2 * HALF_W + 2; // partial product
  localparam int unsigned VOL_W   = 140;           // region products and sums

  // Weights: unsigned Q0.30 with one integer bit, so that 1.0 fits
  localparam int unsigned WFR       = 30;
  localparam int unsigned WGT_W     = WFR + 1;
  localparam logic [WGT_W-1:0] WONE = WGT_W'(1) << WFR;
  localparam int unsigned DIV_STEPS = WFR;

  // Square root of the squared distance
  localparam int unsigned SQ_IN_W  = 64;
  localparam int unsigned SQ_STEPS = SQ_IN_W / 2;
  localparam int unsigned REM_W    = SQ_STEPS + 4;

  localparam int unsigned REG_W = 3;

  // Voronoi region of the closest point
  typedef enum logic [REG_W-1:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_EDGE_AB = 3'd2,
    REG_VERT_C  = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } region_e;

  // Three components, index 0 is x
  typedef logic [2:0][CRD_W-1:0] vec_t;
  typedef logic [2:0][DIF_W-1:0] dvec_t;

  // Dot product pairs of the six region products:
  // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4 (d1 has index 0)
  localparam logic [2:0] PAIR_L [6] = '{3'd0, 3'd2, 3'd4, 3'd0, 3'd2, 3'd4};
  localparam logic [2:0] PAIR_R [6] = '{3'd3, 3'd1, 3'd1, 3'd5, 3'd5, 3'd3};

endpackage
`default_nettype wire

>>> design/ptd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_in_if: query channel
// Query point and triangle vertices with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptd_in_if;
  import ptd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;
  logic signed [CRD_W-1:0] vert_a_x;
  logic signed [CRD_W-1:0] vert_a_y;
  logic signed [CRD_W-1:0] vert_a_z;
  logic signed [CRD_W-1:0] vert_b_x;
  logic signed [CRD_W-1:0] vert_b_y;
  logic signed [CRD_W-1:0] vert_b_z;
  logic signed [CRD_W-1:0] vert_c_x;
  logic signed [CRD_W-1:0] vert_c_y;
  logic signed [CRD_W-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface
`default_nettype wire

>>> design/ptd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_out_if: result channel
// Closest point, distance and region with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptd_out_if;
  import ptd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] near_x;
  logic signed [CRD_W-1:0] near_y;
  logic signed [CRD_W-1:0] near_z;
  logic [CRD_W-1:0]        distance;
  logic [REG_W-1:0]        region;

  modport source (
    output valid, near_x, near_y, near_z, distance, region,
    input  ready
  );

  modport sink (
    input  valid, near_x, near_y, near_z, distance, region,
    output ready
  );
endinterface
`default_nettype wire

>>> design/ptd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_div: pipelined weight divider
// Quotient num/den as unsigned Q0.30, truncated, clamped to [0, 1]. A sign
// stage followed by one restoring step per quotient bit.
// ----------------------------------------------------------------------------
module ptd_div (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [ptd_pkg::VOL_W-1:0]   num_i,
  input  wire logic signed [ptd_pkg::VOL_W-1:0]   den_i,
  output logic             [ptd_pkg::WGT_W-1:0]   wgt_o
);
  import ptd_pkg::*;

  logic [VOL_W-1:0]     rem_q  [DIV_STEPS];
  logic [VOL_W-1:0]     dvs_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q  [DIV_STEPS+1];
  logic                 zero_q [DIV_STEPS+1];
  logic                 full_q [DIV_STEPS+1];

  logic             zero_d;
  logic [VOL_W-1:0] mag_n;
  logic [VOL_W-1:0] mag_d;

  // Force zero on a zero operand or opposite signs, take magnitudes
  always_comb begin
    zero_d = (num_i == 0) || (den_i == 0) || (num_i[VOL_W-1] != den_i[VOL_W-1]);
    mag_n  = num_i[VOL_W-1] ? -num_i : num_i;
    mag_d  = den_i[VOL_W-1] ? -den_i : den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= mag_n;
      dvs_q[0]  <= mag_d;
      quo_q[0]  <= '0;
      zero_q[0] <= zero_d;
      full_q[0] <= 1'b0;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [VOL_W-1:0] dbl;
    logic             ge;

    assign dbl = {rem_q[k-1][VOL_W-2:0], 1'b0};
    assign ge  = dbl >= dvs_q[k-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= {quo_q[k-1][DIV_STEPS-2:0], ge};
        zero_q[k] <= zero_q[k-1];
        full_q[k] <= (k == 1) ? (rem_q[0] >= dvs_q[0]) : full_q[k-1];
      end
    end

    if (k < DIV_STEPS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (dbl - dvs_q[k-1]) : dbl;
          dvs_q[k] <= dvs_q[k-1];
        end
      end
    end
  end

  // Apply the zero and full-scale cases
  always_comb begin
    if (zero_q[DIV_STEPS]) begin
      wgt_o = '0;
    end else if (full_q[DIV_STEPS]) begin
      wgt_o = WONE;
    end else begin
      wgt_o = {1'b0, quo_q[DIV_STEPS]};
    end
  end

endmodule
`default_nettype wire

>>> design/ptd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_sqrt: pipelined integer square root
// Floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ptd_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [ptd_pkg::SQ_IN_W-1:0]       x_i,
  output logic      [ptd_pkg::SQ_STEPS-1:0]      root_o
);
  import ptd_pkg::*;

  logic [SQ_IN_W-1:0]  rad_q  [SQ_STEPS-1];
  logic [REM_W-1:0]    rem_q  [SQ_STEPS-1];
  logic [SQ_STEPS-1:0] root_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SQ_IN_W-1:0]  src_x;
    logic [REM_W-1:0]    src_rem;
    logic [SQ_STEPS-1:0] src_root;
    logic [REM_W-1:0]    rem2;
    logic [REM_W-1:0]    trial;
    logic                ge;

    // Stage source: the input for the first step, else the previous step
    if (k == 0) begin : g_first
      assign src_x    = x_i;
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_next
      assign src_x    = rad_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_root = root_q[k-1];
    end

    // Bring down two radicand bits, try the next root bit
    assign rem2  = {src_rem[REM_W-3:0], src_x[SQ_IN_W-1 -: 2]};
    assign trial = REM_W'({src_root, 2'b01});
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {src_root[SQ_STEPS-2:0], ge};
      end
    end

    if (k < SQ_STEPS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (rem2 - trial) : rem2;
          rad_q[k] <= {src_x[SQ_IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[SQ_STEPS-1];

endmodule
`default_nettype wire

>>> design/point_triangle_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_triangle_distance: closest point on a 3-D triangle
// Returns the closest point, the Euclidean distance and the Voronoi region
// for a query point and three vertices, all signed Q16.16.
// ----------------------------------------------------------------------------
// One query enters every clock cycle unless the output stalls the pipeline.
// Its depth is set by the two bit-serial pipelines: 31 stages of the weight
// divider (a sign stage plus one stage per quotient bit) and 32 stages of the
// square root (one stage per root bit), plus 12 arithmetic stages. The whole
// pipeline holds while a finished result waits on the output; a stalled
// result blocks new queries only when it sits in the last stage.
// ----------------------------------------------------------------------------
module point_triangle_distance (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptd_in_if.sink    in_i,
  ptd_out_if.source out_o
);
  import ptd_pkg::*;

  localparam int unsigned DIV_LAT = DIV_STEPS + 1;
  localparam int unsigned DIV_OUT = 6 + DIV_LAT;
  localparam int unsigned LAT     = DIV_OUT + 6 + SQ_STEPS;
  localparam int unsigned BL_W    = CRD_W + WFR + 5;
  localparam int unsigned NR_W    = CRD_W + 2;
  localparam int unsigned DD_W    = NR_W + 1;
  localparam int unsigned SQ_W    = 2 * NR_W;
  localparam int unsigned SUM_W   = SQ_W + 2;

  typedef struct packed {
    vec_t  p;
    vec_t  a;
    vec_t  b;
    vec_t  c;
    dvec_t ab;
    dvec_t ac;
    dvec_t cb;
  } geo_t;

  typedef struct packed {
    vec_t    p;
    vec_t    base;
    dvec_t   e1;
    dvec_t   e2;
    region_e region;
  } bl_t;

  typedef struct packed {
    vec_t    near;
    region_e region;
    logic    sat;
  } sq_t;

  function automatic dvec_t vsub(vec_t l, vec_t r);
    dvec_t res;
    for (int i = 0; i < 3; i++) begin
      res[i] = DIF_W'($signed(l[i])) - DIF_W'($signed(r[i]));
    end
    return res;
  endfunction

  function automatic logic signed [VOL_W-1:0] join_pp(
    logic signed [PP_W-1:0] hh, logic signed [PP_W-1:0] hl,
    logic signed [PP_W-1:0] lh, logic signed [PP_W-1:0] ll);
    logic signed [VOL_W-1:0] mid;
    mid = VOL_W'(hl) + VOL_W'(lh);
    return (VOL_W'(hh) <<< (2 * HALF_W)) + (mid <<< HALF_W) + VOL_W'(ll);
  endfunction

  logic           adv;
  logic [LAT-1:0] vld_q;

  // Advance every stage unless the result in the last stage is held
  assign adv        = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // Stage 1: differences
  vec_t  pin, ain, bin, cin;
  geo_t  geo1_q, geo2_q, geo3_q, geo4_q, geo5_q, geo6_q;
  dvec_t ap1_q, bp1_q, cp1_q;

  assign pin = {in_i.point_z, in_i.point_y, in_i.point_x};
  assign ain = {in_i.vert_a_z, in_i.vert_a_y, in_i.vert_a_x};
  assign bin = {in_i.vert_b_z, in_i.vert_b_y, in_i.vert_b_x};
  assign cin = {in_i.vert_c_z, in_i.vert_c_y, in_i.vert_c_x};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo1_q.p  <= pin;
      geo1_q.a  <= ain;
      geo1_q.b  <= bin;
      geo1_q.c  <= cin;
      geo1_q.ab <= vsub(bin, ain);
      geo1_q.ac <= vsub(cin, ain);
      geo1_q.cb <= vsub(cin, bin);
      ap1_q     <= vsub(pin, ain);
      bp1_q     <= vsub(pin, bin);
      cp1_q     <= vsub(pin, cin);
    end
  end

  // Stage 2: terms of the six dot products
  dvec_t                   ev [6];
  dvec_t                   fv [6];
  logic signed [PRD_W-1:0] pr_d [6][3];
  logic signed [PRD_W-1:0] pr_q [6][3];

  always_comb begin
    ev[0] = geo1_q.ab; fv[0] = ap1_q;
    ev[1] = geo1_q.ac; fv[1] = ap1_q;
    ev[2] = geo1_q.ab; fv[2] = bp1_q;
    ev[3] = geo1_q.ac; fv[3] = bp1_q;
    ev[4] = geo1_q.ab; fv[4] = cp1_q;
    ev[5] = geo1_q.ac; fv[5] = cp1_q;
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 3; j++) begin
        pr_d[k][j] = $signed(ev[k][j]) * $signed(fv[k][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q   <= pr_d;
      geo2_q <= geo1_q;
    end
  end

  // Stage 3: dot products d1..d6
  logic signed [DOT_W-1:0] dot_d [6];
  logic signed [DOT_W-1:0] dot_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dot_d[k] = DOT_W'(pr_q[k][0]) + DOT_W'(pr_q[k][1]) + DOT_W'(pr_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q  <= dot_d;
      geo3_q <= geo2_q;
    end
  end

  // Stage 4: partial products of the six region products
  logic signed [PP_W-1:0]  hh_d [6], hl_d [6], lh_d [6], ll_d [6];
  logic signed [PP_W-1:0]  hh_q [6], hl_q [6], lh_q [6], ll_q [6];
  logic signed [DOT_W-1:0] dot4_q [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hh_d[i] = $signed(dot_q[PAIR_L[i]][DOT_W-1:HALF_W])
              * $signed(dot_q[PAIR_R[i]][DOT_W-1:HALF_W]);
      hl_d[i] = $signed(dot_q[PAIR_L[i]][DOT_W-1:HALF_W])
              * $signed({1'b0, dot_q[PAIR_R[i]][HALF_W-1:0]});
      lh_d[i] = $signed({1'b0, dot_q[PAIR_L[i]][HALF_W-1:0]})
              * $signed(dot_q[PAIR_R[i]][DOT_W-1:HALF_W]);
      ll_d[i] = $signed({1'b0, dot_q[PAIR_L[i]][HALF_W-1:0]})
              * $signed({1'b0, dot_q[PAIR_R[i]][HALF_W-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      lh_q   <= lh_d;
      ll_q   <= ll_d;
      dot4_q <= dot_q;
      geo4_q <= geo3_q;
    end
  end

  // Stage 5: region products va, vb, vc
  logic signed [VOL_W-1:0] big [6];
  logic signed [VOL_W-1:0] va5_q, vb5_q, vc5_q;
  logic signed [DOT_W-1:0] dot5_q [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      big[i] = join_pp(hh_q[i], hl_q[i], lh_q[i], ll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vc5_q  <= big[0] - big[1];
      vb5_q  <= big[2] - big[3];
      va5_q  <= big[4] - big[5];
      dot5_q <= dot4_q;
      geo5_q <= geo4_q;
    end
  end

  // Stage 6: region tests and denominators
  logic signed [DOT_W:0]   n1_d, n2_d, den2_d, den4_d;
  logic signed [DOT_W+1:0] den5_d;
  logic signed [VOL_W-1:0] denf_d;
  region_e                 reg_d;

  region_e                 reg6_q;
  logic signed [DOT_W-1:0] d1_6_q, d2_6_q;
  logic signed [DOT_W:0]   n1_6_q, den2_6_q, den4_6_q;
  logic signed [DOT_W+1:0] den5_6_q;
  logic signed [VOL_W-1:0] vb6_q, vc6_q, denf6_q;

  always_comb begin
    n1_d   = (DOT_W+1)'(dot5_q[3]) - (DOT_W+1)'(dot5_q[2]);
    n2_d   = (DOT_W+1)'(dot5_q[4]) - (DOT_W+1)'(dot5_q[5]);
    den2_d = (DOT_W+1)'(dot5_q[0]) - (DOT_W+1)'(dot5_q[2]);
    den4_d = (DOT_W+1)'(dot5_q[1]) - (DOT_W+1)'(dot5_q[5]);
    den5_d = (DOT_W+2)'(n1_d) + (DOT_W+2)'(n2_d);
    denf_d = va5_q + vb5_q + vc5_q;
    priority if (dot5_q[0] <= 0 && dot5_q[1] <= 0) begin
      reg_d = REG_VERT_A;
    end else if (dot5_q[2] >= 0 && dot5_q[2] >= dot5_q[3]) begin
      reg_d = REG_VERT_B;
    end else if (vc5_q <= 0 && dot5_q[0] >= 0 && dot5_q[2] <= 0) begin
      reg_d = REG_EDGE_AB;
    end else if (dot5_q[5] >= 0 && dot5_q[5] >= dot5_q[4]) begin
      reg_d = REG_VERT_C;
    end else if (vb5_q <= 0 && dot5_q[1] >= 0 && dot5_q[5] <= 0) begin
      reg_d = REG_EDGE_AC;
    end else if (va5_q <= 0 && n1_d >= 0 && n2_d >= 0) begin
      reg_d = REG_EDGE_BC;
    end else begin
      reg_d = REG_FACE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      reg6_q   <= reg_d;
      d1_6_q   <= dot5_q[0];
      d2_6_q   <= dot5_q[1];
      n1_6_q   <= n1_d;
      den2_6_q <= den2_d;
      den4_6_q <= den4_d;
      den5_6_q <= den5_d;
      vb6_q    <= vb5_q;
      vc6_q    <= vc5_q;
      denf6_q  <= denf_d;
      geo6_q   <= geo5_q;
    end
  end

  // Stage 7: pick the quotients and the blend terms for the region
  logic signed [VOL_W-1:0] num0_d, den0_d, num1_d, den1_d;
  logic signed [VOL_W-1:0] num0_q, den0_q, num1_q, den1_q;
  bl_t                     bl7_d, bl7_q;

  always_comb begin
    num0_d       = '0;
    den0_d       = '0;
    num1_d       = '0;
    den1_d       = '0;
    bl7_d.p      = geo6_q.p;
    bl7_d.base   = geo6_q.a;
    bl7_d.e1     = '0;
    bl7_d.e2     = '0;
    bl7_d.region = reg6_q;
    unique case (reg6_q)
      REG_VERT_A: begin
        bl7_d.base = geo6_q.a;
      end
      REG_VERT_B: begin
        bl7_d.base = geo6_q.b;
      end
      REG_VERT_C: begin
        bl7_d.base = geo6_q.c;
      end
      REG_EDGE_AB: begin
        num0_d   = VOL_W'(d1_6_q);
        den0_d   = VOL_W'(den2_6_q);
        bl7_d.e1 = geo6_q.ab;
      end
      REG_EDGE_AC: begin
        num0_d   = VOL_W'(d2_6_q);
        den0_d   = VOL_W'(den4_6_q);
        bl7_d.e1 = geo6_q.ac;
      end
      REG_EDGE_BC: begin
        num0_d     = VOL_W'(n1_6_q);
        den0_d     = VOL_W'(den5_6_q);
        bl7_d.base = geo6_q.b;
        bl7_d.e1   = geo6_q.cb;
      end
      REG_FACE: begin
        num0_d   = vb6_q;
        den0_d   = denf6_q;
        num1_d   = vc6_q;
        den1_d   = denf6_q;
        bl7_d.e1 = geo6_q.ab;
        bl7_d.e2 = geo6_q.ac;
      end
      default: begin
        bl7_d.base = geo6_q.a;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num0_q <= num0_d;
      den0_q <= den0_d;
      num1_q <= num1_d;
      den1_q <= den1_d;
      bl7_q  <= bl7_d;
    end
  end

  // Weight dividers, with the blend terms carried alongside
  logic [WGT_W-1:0] wgt0, wgt1;
  bl_t              dbl_q [DIV_LAT];

  ptd_div u_div0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num0_q),
    .den_i (den0_q),
    .wgt_o (wgt0)
  );

  ptd_div u_div1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num1_q),
    .den_i (den1_q),
    .wgt_o (wgt1)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dbl_q[0] <= bl7_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dbl_q[i] <= dbl_q[i-1];
      end
    end
  end

  // Stage 8: hold the weight sum at or below one
  logic [WGT_W-1:0] lim;
  logic [WGT_W-1:0] w0_q, w1_q;
  bl_t              bl8_q;

  assign lim = WONE - wgt0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q  <= wgt0;
      w1_q  <= (wgt1 > lim) ? lim : wgt1;
      bl8_q <= dbl_q[DIV_LAT-1];
    end
  end

  // Stage 9: weighted edge vectors
  logic signed [DIF_W+WGT_W:0] pw1_d [3], pw2_d [3];
  logic signed [DIF_W+WGT_W:0] pw1_q [3], pw2_q [3];
  bl_t                         bl9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw1_d[i] = $signed(bl8_q.e1[i]) * $signed({1'b0, w0_q});
      pw2_d[i] = $signed(bl8_q.e2[i]) * $signed({1'b0, w1_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw1_q <= pw1_d;
      pw2_q <= pw2_d;
      bl9_q <= bl8_q;
    end
  end

  // Stage 10: closest point, truncated toward zero
  logic signed [BL_W-1:0] tot [3];
  logic signed [BL_W-1:0] tb  [3];
  logic signed [NR_W-1:0] q_d [3];
  logic signed [NR_W-1:0] q_q [3];
  vec_t                   p10_q;
  region_e                reg10_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i] = (BL_W'($signed(bl9_q.base[i])) <<< WFR)
             + BL_W'(pw1_q[i]) + BL_W'(pw2_q[i]);
      tb[i]  = tot[i] + (tot[i][BL_W-1] ? BL_W'(WONE - 1'b1) : BL_W'(0));
      q_d[i] = NR_W'(tb[i] >>> WFR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_q     <= q_d;
      p10_q   <= bl9_q.p;
      reg10_q <= bl9_q.region;
    end
  end

  // Stage 11: squared differences
  logic signed [DD_W-1:0] dd  [3];
  logic [NR_W-1:0]        mag [3];
  logic [SQ_W-1:0]        sq_q [3];
  vec_t                   near11_q;
  region_e                reg11_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]  = DD_W'($signed(p10_q[i])) - DD_W'(q_q[i]);
      mag[i] = dd[i][DD_W-1] ? NR_W'(-dd[i]) : NR_W'(dd[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]     <= mag[i] * mag[i];
        near11_q[i] <= q_q[i][CRD_W-1:0];
      end
      reg11_q <= reg10_q;
    end
  end

  // Stage 12: squared distance, flag overflow of the root input
  logic [SUM_W-1:0]   sum_d;
  logic [SQ_IN_W-1:0] x12_q;
  sq_t                sp12_q;

  assign sum_d = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x12_q         <= sum_d[SQ_IN_W-1:0];
      sp12_q.sat    <= |sum_d[SUM_W-1:SQ_IN_W];
      sp12_q.near   <= near11_q;
      sp12_q.region <= reg11_q;
    end
  end

  // Square root, with the result fields carried alongside
  logic [SQ_STEPS-1:0] root;
  sq_t                 spl_q [SQ_STEPS];

  ptd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (x12_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spl_q[0] <= sp12_q;
      for (int i = 1; i < SQ_STEPS; i++) begin
        spl_q[i] <= spl_q[i-1];
      end
    end
  end

  // Result transaction
  assign out_o.valid    = vld_q[LAT-1];
  assign out_o.near_x   = spl_q[SQ_STEPS-1].near[0];
  assign out_o.near_y   = spl_q[SQ_STEPS-1].near[1];
  assign out_o.near_z   = spl_q[SQ_STEPS-1].near[2];
  assign out_o.distance = spl_q[SQ_STEPS-1].sat ? '1 : root;
  assign out_o.region   = spl_q[SQ_STEPS-1].region;

  // Checks on stalling and on the weights
  logic div_vert;
  assign div_vert = (dbl_q[DIV_LAT-1].region == REG_VERT_A)
                 || (dbl_q[DIV_LAT-1].region == REG_VERT_B)
                 || (dbl_q[DIV_LAT-1].region == REG_VERT_C);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_wgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_OUT] |-> (wgt0 <= WONE) && (wgt1 <= WONE))
    else $error("weight above one");

  a_vert_wgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_OUT] && div_vert |-> (wgt0 == '0) && (wgt1 == '0))
    else $error("vertex region with a non-zero weight");

  a_wgt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_OUT+1] |-> ({1'b0, w0_q} + {1'b0, w1_q}) <= {1'b0, WONE})
    else $error("weight sum above one after clamp");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for point_triangle_distance
// Drives queries through the valid/ready channels with random gaps on both
// sides and checks each result, field by field, against a typed answer or an
// exact integer model of the closest-point search held here.
// ----------------------------------------------------------------------------
module tb_top;
  import ptd_pkg::*;

  typedef logic signed [199:0] big_t;

  typedef struct packed {
    vec_t p;
    vec_t a;
    vec_t b;
    vec_t c;
  } query_t;

  typedef struct packed {
    vec_t        near;
    logic [31:0] dst;
    region_e     rgn;
  } answer_t;

  typedef struct packed {
    query_t  q;
    logic    typed;
    answer_t ans;
  } row_t;

  logic clk_i;
  logic rst_ni;

  ptd_in_if  in_if ();
  ptd_out_if out_if ();

  point_triangle_distance i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  answer_t answers_due[$];
  row_t    rows[$];
  int      n_errors;
  bit      no_gaps;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Exact closest-point model
  // --------------------------------------------------------------------------
  function automatic big_t dot3(big_t u[3], big_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // Quotient num/den as Q0.30, truncated, clamped to [0, 1]
  function automatic logic [WGT_W-1:0] quot_q30(big_t num, big_t den);
    big_t n, d, r;
    if (den == 0 || num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (n >= d) return WONE;
    r = (n <<< WFR) / d;
    return r[WGT_W-1:0];
  endfunction

  function automatic big_t mix(big_t base, big_t e1, logic [WGT_W-1:0] w1,
                               big_t e2, logic [WGT_W-1:0] w2);
    big_t one_w, bw1, bw2;
    one_w = big_t'(1) <<< WFR;
    bw1   = w1;
    bw2   = w2;
    return (base * one_w + e1 * bw1 + e2 * bw2) / one_w;
  endfunction

  function automatic logic [31:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bt;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x   = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[31:0];
  endfunction

  function automatic answer_t nearest_point(query_t q);
    big_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], nr[3];
    big_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, n1, dif, sum;
    logic [WGT_W-1:0] v, w;
    answer_t r;
    for (int i = 0; i < 3; i++) begin
      p[i]  = $signed(q.p[i]);
      a[i]  = $signed(q.a[i]);
      b[i]  = $signed(q.b[i]);
      c[i]  = $signed(q.c[i]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    vc = d1 * d4 - d3 * d2;
    vb = d5 * d2 - d1 * d6;
    va = d3 * d6 - d5 * d4;
    // Regions in priority order: A, B, AB, C, AC, BC, face
    if (d1 <= 0 && d2 <= 0) begin
      r.rgn = REG_VERT_A;
      nr = a;
    end else if (d3 >= 0 && d4 <= d3) begin
      r.rgn = REG_VERT_B;
      nr = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      r.rgn = REG_EDGE_AB;
      v = quot_q30(d1, d1 - d3);
      for (int i = 0; i < 3; i++) nr[i] = mix(a[i], ab[i], v, 0, '0);
    end else if (d6 >= 0 && d5 <= d6) begin
      r.rgn = REG_VERT_C;
      nr = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      r.rgn = REG_EDGE_AC;
      w = quot_q30(d2, d2 - d6);
      for (int i = 0; i < 3; i++) nr[i] = mix(a[i], ac[i], w, 0, '0);
    end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
      r.rgn = REG_EDGE_BC;
      n1 = d4 - d3;
      w = quot_q30(n1, n1 + (d5 - d6));
      for (int i = 0; i < 3; i++) nr[i] = mix(b[i], c[i] - b[i], w, 0, '0);
    end else begin
      r.rgn = REG_FACE;
      den = va + vb + vc;
      v = quot_q30(vb, den);
      w = quot_q30(vc, den);
      if (w > WONE - v) w = WONE - v;
      for (int i = 0; i < 3; i++) nr[i] = mix(a[i], ab[i], v, ac[i], w);
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      dif = p[i] - nr[i];
      sum = sum + dif * dif;
      r.near[i] = nr[i][31:0];
    end
    r.dst = (sum[199:64] != 0) ? 32'hFFFF_FFFF : floor_sqrt(sum[63:0]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic vec_t mk(int x, int y, int z);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  function automatic vec_t jitter(vec_t base, int span);
    vec_t v;
    for (int i = 0; i < 3; i++) v[i] = base[i] + $urandom_range(0, 2 * span) - span;
    return v;
  endfunction

  function automatic query_t random_query();
    query_t q;
    vec_t   ctr;
    int     sel, k;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) ctr[i] = $urandom;
    if (sel < 3) begin
      // full-range coordinates
      q.p = {$urandom, $urandom, $urandom};
      q.a = {$urandom, $urandom, $urandom};
      q.b = {$urandom, $urandom, $urandom};
      q.c = {$urandom, $urandom, $urandom};
    end else if (sel < 8) begin
      // local triangle with the point nearby, so every region gets hit
      q.a = jitter(ctr, 1 << 20);
      q.b = jitter(ctr, 1 << 20);
      q.c = jitter(ctr, 1 << 20);
      q.p = jitter(ctr, 1 << 21);
    end else if (sel == 8) begin
      // degenerate: collinear or coincident vertices
      q.a = jitter(ctr, 1 << 18);
      q.b = ($urandom_range(0, 1) != 0) ? q.a : jitter(ctr, 1 << 18);
      k   = $urandom_range(0, 4) - 2;
      for (int i = 0; i < 3; i++) q.c[i] = q.a[i] + k * (q.b[i] - q.a[i]);
      q.p = jitter(ctr, 1 << 19);
    end else begin
      // coordinates near the extremes
      for (int i = 0; i < 3; i++) begin
        q.p[i] = ($urandom_range(0, 1) != 0) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
                                             : 32'h8000_0000 + $urandom_range(0, 65535);
        q.a[i] = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        q.b[i] = $urandom;
        q.c[i] = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : $urandom;
      end
    end
    return q;
  endfunction

  // Present one query, hold it until accepted, then idle a random gap
  task automatic send_query(query_t q, logic typed, answer_t ans);
    int gap;
    in_if.valid    <= 1'b1;
    in_if.point_x  <= q.p[0];
    in_if.point_y  <= q.p[1];
    in_if.point_z  <= q.p[2];
    in_if.vert_a_x <= q.a[0];
    in_if.vert_a_y <= q.a[1];
    in_if.vert_a_z <= q.a[2];
    in_if.vert_b_x <= q.b[0];
    in_if.vert_b_y <= q.b[1];
    in_if.vert_b_z <= q.b[2];
    in_if.vert_c_x <= q.c[0];
    in_if.vert_c_y <= q.c[1];
    in_if.vert_c_z <= q.c[2];
    do @(posedge clk_i); while (!in_if.ready);
    answers_due.insert(answers_due.size(), typed ? ans : nearest_point(q));
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls and checking
  // --------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        n_errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_if.near_x !== want.near[0]) begin
          $display("%0t: near_x expected %h actual %h", $time, want.near[0], out_if.near_x);
          n_errors++;
        end
        if (out_if.near_y !== want.near[1]) begin
          $display("%0t: near_y expected %h actual %h", $time, want.near[1], out_if.near_y);
          n_errors++;
        end
        if (out_if.near_z !== want.near[2]) begin
          $display("%0t: near_z expected %h actual %h", $time, want.near[2], out_if.near_z);
          n_errors++;
        end
        if (out_if.distance !== want.dst) begin
          $display("%0t: distance expected %h actual %h", $time, want.dst, out_if.distance);
          n_errors++;
        end
        if (out_if.region !== want.rgn) begin
          $display("%0t: region expected %0d actual %0d", $time, want.rgn, out_if.region);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t    rw;
    answer_t none;
    int      waited;
    none     = '0;
    n_errors = 0;
    no_gaps  = 1'b0;
    rst_ni   = 1'b0;
    in_if.valid <= 1'b0;
    {in_if.point_x, in_if.point_y, in_if.point_z} <= '0;
    {in_if.vert_a_x, in_if.vert_a_y, in_if.vert_a_z} <= '0;
    {in_if.vert_b_x, in_if.vert_b_y, in_if.vert_b_z} <= '0;
    {in_if.vert_c_x, in_if.vert_c_y, in_if.vert_c_z} <= '0;

    // Typed rows: everything at the origin, vertex hits, saturation
    add_row('{'{mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0), mk(0, 0, 0)}, 1'b1,
              '{mk(0, 0, 0), 32'd0, REG_VERT_A}});
    add_row('{'{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)}, 1'b1,
              '{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                32'hFFFF_FFFF, REG_VERT_A}});
    add_row('{'{mk(0, 0, 1 << 16), mk(0, 0, 0), mk(1 << 16, 0, 0), mk(0, 1 << 16, 0)},
              1'b1, '{mk(0, 0, 0), 32'h0001_0000, REG_VERT_A}});
    add_row('{'{mk(1 << 16, 0, 0), mk(0, 0, 0), mk(1 << 16, 0, 0), mk(0, 1 << 16, 0)},
              1'b1, '{mk(1 << 16, 0, 0), 32'd0, REG_VERT_B}});
    add_row('{'{mk(0, 1 << 16, 0), mk(0, 0, 0), mk(1 << 16, 0, 0), mk(0, 1 << 16, 0)},
              1'b1, '{mk(0, 1 << 16, 0), 32'd0, REG_VERT_C}});
    // Predicted rows: edges, face, degenerate triangles, extremes
    add_row('{'{mk(1 << 15, -5 << 14, 3), mk(0, 0, 0), mk(1 << 16, 0, 0),
                mk(0, 1 << 16, 0)}, 1'b0, none});
    add_row('{'{mk(-7 << 14, 1 << 15, 9), mk(0, 0, 0), mk(1 << 16, 0, 0),
                mk(0, 1 << 16, 0)}, 1'b0, none});
    add_row('{'{mk(3 << 16, 3 << 16, -1 << 16), mk(0, 0, 0), mk(1 << 16, 0, 0),
                mk(0, 1 << 16, 0)}, 1'b0, none});
    add_row('{'{mk(1 << 13, 1 << 14, 1 << 16), mk(0, 0, 0), mk(1 << 16, 0, 0),
                mk(0, 1 << 16, 0)}, 1'b0, none});
    add_row('{'{mk(3, 5, -7), mk(1, 2, 3), mk(1, 2, 3), mk(1, 2, 3)}, 1'b0, none});
    add_row('{'{mk(1 << 17, 5, 0), mk(0, 0, 0), mk(1 << 16, 0, 0), mk(2 << 16, 0, 0)},
              1'b0, none});
    add_row('{'{mk(3 << 16, 1, 1), mk(0, 0, 0), mk(1 << 16, 0, 0), mk(-1 << 16, 0, 0)},
              1'b0, none});
    add_row('{'{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
                mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
                mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000),
                mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF)}, 1'b0, none});
    add_row('{'{mk(0, 0, 0), mk(32'h8000_0000, 32'h8000_0000, 0),
                mk(32'h7FFF_FFFF, 32'h8000_0000, 0),
                mk(0, 32'h7FFF_FFFF, 0)}, 1'b0, none});
    add_row('{'{mk(-1, -1, -1), mk(32'h7FFF_FFFF, 0, 0), mk(0, 32'h7FFF_FFFF, 0),
                mk(0, 0, 32'h7FFF_FFFF)}, 1'b0, none});
    add_row('{'{mk(1, 1, 1), mk(1, 0, 0), mk(0, 1, 0), mk(0, 0, 1)}, 1'b0, none});

    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (rows[i]) begin
      rw = rows[i];
      send_query(rw.q, rw.typed, rw.ans);
    end

    // Random queries, with a gap-free stretch and one full drain
    for (int n = 0; n < 1000; n++) begin
      no_gaps = (n >= 400 && n < 550);
      if (n == 700) begin
        in_if.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk_i);
      end
      send_query(random_query(), 1'b0, none);
    end
    in_if.valid <= 1'b0;

    // Drain
    waited = 0;
    while (answers_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && answers_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (answers_due.size() != 0)
        $display("%0t: %0d results never arrived", $time, answers_due.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ptd_pkg.sv
design/ptd_in_if.sv
design/ptd_out_if.sv
design/ptd_div.sv
design/ptd_sqrt.sv
design/point_triangle_distance.sv
tb/tb_top.sv
